>>> sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define SAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked at every rising edge outside reset
`define SAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/saf_pkg.sv
`timescale 1ns / 1ps

package saf_pkg;

  // default sizes
  localparam int MAX_FRAMES_DEF = 64;
  localparam int TIME_BITS_DEF  = 32;

  // field widths
  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 6;
  localparam int VALUE_W  = 16;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int MODE_W   = 2;
  localparam int DUR_W    = 32;
  localparam int POS_W    = 7;
  localparam int PERIOD_W = 8;
  localparam int IDX_W    = 2;

  // word layouts
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;
  localparam int SLOT_LSB   = 0;
  localparam int VALUE_LSB  = SLOT_LSB + SLOT_W;
  localparam int TIME_LSB   = VALUE_LSB + VALUE_W;

  // register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_PLAY_MODE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_DURATION    = 2'd2;

  // register reset values
  localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = 7'd1;
  localparam logic [DUR_W-1:0]   DURATION_RST    = 32'd1000000;

  // play modes
  localparam logic [MODE_W-1:0] MODE_ONCE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOOP     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PINGPONG = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO     = 2'd3;

  // item kinds
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> sv/saf_divider.sv
`timescale 1ns / 1ps

module saf_divider
  import saf_pkg::*;
#(
  parameter int W   = 40,
  parameter int DVW = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [W-1:0]   dividend,
  input  logic [DVW-1:0] divisor,
  output logic [W-1:0]   quotient,
  output logic [DVW-1:0] remainder,
  output div_stat_t      stat
);

  localparam int CW = $clog2(W);

  logic [W-1:0]   dvd_r;
  logic [DVW-1:0] dvs_r;
  logic [DVW-1:0] rem_r;
  logic [CW-1:0]  cnt_r;
  logic           busy_r;
  logic           done_r;

  logic [DVW:0]   shifted;
  logic [DVW:0]   diff;
  logic           fits;
  logic [DVW-1:0] rem_step;

  // one restoring step per cycle, quotient bits shift into the dividend register
  always_comb begin
    shifted  = {rem_r, dvd_r[W-1]};
    fits     = (shifted >= {1'b0, dvs_r});
    diff     = shifted - {1'b0, dvs_r};
    rem_step = fits ? diff[DVW-1:0] : shifted[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[W-2:0], fits};
      rem_r <= rem_step;
    end
  end

  assign quotient  = dvd_r;
  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> sv/saf_table.sv
`timescale 1ns / 1ps

module saf_table
  import saf_pkg::*;
#(
  parameter int DEPTH = MAX_FRAMES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [VALUE_W-1:0]       wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [VALUE_W-1:0]       rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/sprite_anim_frame_select.sv
`timescale 1ns / 1ps

// channel | direction | word contents
// in_     | slave     | tuser: func; tdata: entry_slot, entry_value, time_ticks
// out_    | master    | tdata: sprite_index, frame_position
// cfg_    | write     | cfg_index selects frame_count, play_mode or duration_ticks
//
// a table write does not leave the idle state, so the input stays ready
// a query runs through one shared bit-serial divider, one quotient bit a cycle over
// PW = min(TIME_BITS,32)+8 bits: once mode divides once (product over duration),
// loop and ping-pong divide again for the index mod period, sprite-zero mode skips it
// the finished result sits in the output register, so the next item can enter
// while it waits on out_tready; reset is synchronous and clears control and configuration only

module sprite_anim_frame_select
  import saf_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_slot[5:0], entry_value[21:6], time_ticks[53:22]
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sprite_index[15:0], frame_position[22:16]
  // configuration writes
  input  logic                  cfg_we,
  input  logic [IDX_W-1:0]      cfg_index,
  input  logic [DUR_W-1:0]      cfg_wdata
);

  // effective time width: the field carries 32 bits at most
  localparam int TB = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
  // product of time and period, also the divider width
  localparam int PW = TB + PERIOD_W;
  localparam int AW = $clog2(MAX_FRAMES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_QUO,
    S_MOD,
    S_READ,
    S_HOLD
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [COUNT_W-1:0] frame_count_r;
  logic [MODE_W-1:0]  play_mode_r;
  logic [DUR_W-1:0]   duration_r;

  // per-query context
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [COUNT_W-1:0]  n_r, n_nxt;
  logic [PERIOD_W-1:0] per_r, per_nxt;
  logic [DUR_W-1:0]    dur_r, dur_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic                zero_r, zero_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_sprite_r, out_sprite_nxt;
  logic [POS_W-1:0]    out_pos_r, out_pos_nxt;

  // input word fields
  logic                in_acc;
  logic [FUNC_W-1:0]   in_func;
  logic [SLOT_W-1:0]   in_slot;
  logic [VALUE_W-1:0]  in_value;
  logic [TB-1:0]       in_time;

  // effective settings at accept time
  logic [COUNT_W-1:0]  n_eff;
  logic [PERIOD_W-1:0] per_eff;
  logic [DUR_W-1:0]    dur_eff;

  // divider hookup
  logic                div_start;
  logic [PW-1:0]       div_dvd;
  logic [DUR_W-1:0]    div_dvs;
  logic [PW-1:0]       div_quo;
  logic [DUR_W-1:0]    div_rem;
  div_stat_t           div_stat;

  // table hookup
  logic                tbl_we;
  logic [AW-1:0]       tbl_raddr;
  logic [VALUE_W-1:0]  tbl_rdata;

  logic [PERIOD_W-1:0] rem8;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign in_func   = in_tuser;
  assign in_slot   = in_tdata[SLOT_LSB +: SLOT_W];
  assign in_value  = in_tdata[VALUE_LSB +: VALUE_W];
  assign in_time   = in_tdata[TIME_LSB +: TB];

  // zero count and zero duration act as one; loop and once use the count as period
  assign n_eff   = (frame_count_r == '0) ? COUNT_W'(1) : frame_count_r;
  assign per_eff = (play_mode_r == MODE_PINGPONG) ? ({n_eff, 1'b0} - PERIOD_W'(1))
                                                  : {1'b0, n_eff};
  assign dur_eff = (duration_r == '0) ? DUR_W'(1) : duration_r;

  // writes past the table are dropped
  assign tbl_we = in_acc && (in_func == FUNC_WRITE) && (32'(in_slot) < MAX_FRAMES);

  // table read saturates at the last entry
  assign tbl_raddr = (32'(pos_r) > MAX_FRAMES - 1) ? AW'(MAX_FRAMES - 1) : AW'(pos_r);

  assign rem8 = div_rem[PERIOD_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    n_nxt          = n_r;
    per_nxt        = per_r;
    dur_nxt        = dur_r;
    prod_nxt       = prod_r;
    pos_nxt        = pos_r;
    zero_nxt       = zero_r;
    out_valid_nxt  = out_valid_r;
    out_sprite_nxt = out_sprite_r;
    out_pos_nxt    = out_pos_r;
    div_start      = 1'b0;
    div_dvd        = prod_r;
    div_dvs        = dur_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_func == FUNC_QUERY)) begin
          mode_nxt = play_mode_r;
          n_nxt    = n_eff;
          per_nxt  = per_eff;
          dur_nxt  = dur_eff;
          prod_nxt = PW'(in_time) * PW'(per_eff);
          if (play_mode_r == MODE_ZERO) begin
            zero_nxt  = 1'b1;
            pos_nxt   = '0;
            state_nxt = S_HOLD;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        // frame index: product over duration
        div_start = 1'b1;
        div_dvd   = prod_r;
        div_dvs   = dur_r;
        state_nxt = S_QUO;
      end
      S_QUO: begin
        if (div_stat.done) begin
          if (mode_r == MODE_ONCE) begin
            pos_nxt   = (div_quo > PW'(n_r - COUNT_W'(1))) ? (n_r - COUNT_W'(1))
                                                           : div_quo[POS_W-1:0];
            state_nxt = S_READ;
          end else begin
            // wrap: reuse the divider for index mod period
            div_start = 1'b1;
            div_dvd   = div_quo;
            div_dvs   = DUR_W'(per_r);
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (div_stat.done) begin
          if ((mode_r == MODE_PINGPONG) && (rem8 > {1'b0, n_r - COUNT_W'(1)})) begin
            pos_nxt = POS_W'(per_r - rem8);
          end else begin
            pos_nxt = rem8[POS_W-1:0];
          end
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_sprite_nxt = zero_r ? '0 : tbl_rdata;
          out_pos_nxt    = pos_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      frame_count_r <= FRAME_COUNT_RST;
      play_mode_r   <= MODE_ONCE;
      duration_r    <= DURATION_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FRAME_COUNT: frame_count_r <= cfg_wdata[COUNT_W-1:0];
          REG_PLAY_MODE:   play_mode_r   <= cfg_wdata[MODE_W-1:0];
          REG_DURATION:    duration_r    <= cfg_wdata[DUR_W-1:0];
          default: begin
          end
        endcase
      end
    end
    mode_r       <= mode_nxt;
    n_r          <= n_nxt;
    per_r        <= per_nxt;
    dur_r        <= dur_nxt;
    prod_r       <= prod_nxt;
    pos_r        <= pos_nxt;
    zero_r       <= zero_nxt;
    out_sprite_r <= out_sprite_nxt;
    out_pos_r    <= out_pos_nxt;
  end

  saf_divider #(
    .W   (PW),
    .DVW (DUR_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  saf_table #(
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_slot)),
    .wdata (in_value),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pos_r, out_sprite_r};

endmodule

>>> sv/saf_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module saf_checker
  import saf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [FUNC_W-1:0]     in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  logic in_query;
  logic in_write;

  assign in_query = in_tvalid && in_tready && (in_tuser == FUNC_QUERY);
  assign in_write = in_tvalid && in_tready && (in_tuser == FUNC_WRITE);

  // a stalled result word holds
  `SAF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a query keeps the block busy on the next cycle
  `SAF_ASSERT_NEXT(a_query_busy, clk, rst_n, in_query, !in_tready)

  // a table write never blocks the input
  `SAF_ASSERT_NEXT(a_write_ready, clk, rst_n, in_write, in_tready)

  // clamp, wrap and mirror never give position 127
  `SAF_ASSERT_NOW(a_pos_range, clk, rst_n, out_tvalid, out_tdata[22:16] != 7'd127)

endmodule

bind sprite_anim_frame_select saf_checker u_saf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
